@@ design/pwm_timer_four_mode_12bit_top_defines.svh @@
// Assertion macros for the waveform timer.
`ifndef PWM_TIMER_FOUR_MODE_12BIT_TOP_DEFINES_SVH
`define PWM_TIMER_FOUR_MODE_12BIT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication under clk, off while reset is low
`define PTFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication under clk, off while reset is low
`define PTFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTFM_ASSERT_IMP(lbl, ante, cons, msg)
`define PTFM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/ptfm_pkg.sv @@
package ptfm_pkg;

  localparam int CNT_W = 12;
  localparam int CFG_W = 12;
  localparam int IDX_W = 3;
  localparam int DIV_W = 8;
  localparam int PER_W = DIV_W + 1;

  typedef enum logic [1:0] {
    MODE_ONE_RAMP,
    MODE_TWO_RAMP,
    MODE_FOUR_RAMP,
    MODE_DUAL_SLOPE
  } wave_mode_t;

  typedef enum logic [IDX_W-1:0] {
    IDX_WAVE_MODE,
    IDX_A_SET,
    IDX_A_CLEAR,
    IDX_B_SET,
    IDX_B_CLEAR,
    IDX_OUTPUT_ENABLE,
    IDX_SYNC_DIVIDE,
    IDX_COUNT_DIVIDE
  } cfg_idx_t;

  typedef struct packed {
    wave_mode_t       wave_mode;
    logic [CNT_W-1:0] a_set;
    logic [CNT_W-1:0] a_clear;
    logic [CNT_W-1:0] b_set;
    logic [CNT_W-1:0] b_clear;
    logic [1:0]       output_enable;
    logic [1:0]       sync_divide;
    logic [1:0]       count_divide;
  } cfg_t;

  typedef struct packed {
    logic run;
    logic clear_overflow;
  } in_item_t;

  typedef struct packed {
    logic             wave_a;
    logic             wave_b;
    logic [CNT_W-1:0] count_value;
    logic [1:0]       ramp_phase;
    logic             counting_down;
    logic             overflow_event;
    logic             overflow_flag;
  } out_item_t;

endpackage

@@ design/ptfm_regs.sv @@
module ptfm_regs
  import ptfm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg,
  output logic             restart_req
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic restart_req_r;

  // Decode the register index and merge the write data
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        IDX_WAVE_MODE:     cfg_nxt.wave_mode     = wave_mode_t'(cfg_data[1:0]);
        IDX_A_SET:         cfg_nxt.a_set         = cfg_data[CNT_W-1:0];
        IDX_A_CLEAR:       cfg_nxt.a_clear       = cfg_data[CNT_W-1:0];
        IDX_B_SET:         cfg_nxt.b_set         = cfg_data[CNT_W-1:0];
        IDX_B_CLEAR:       cfg_nxt.b_clear       = cfg_data[CNT_W-1:0];
        IDX_OUTPUT_ENABLE: cfg_nxt.output_enable = cfg_data[1:0];
        IDX_SYNC_DIVIDE:   cfg_nxt.sync_divide   = cfg_data[1:0];
        IDX_COUNT_DIVIDE:  cfg_nxt.count_divide  = cfg_data[1:0];
      endcase
    end
  end

  // Hold the registers; flag a restart for the cycle after any write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r         <= '0;
      restart_req_r <= 1'b0;
    end else begin
      cfg_r         <= cfg_nxt;
      restart_req_r <= cfg_we;
    end
  end

  assign cfg         = cfg_r;
  assign restart_req = restart_req_r;

endmodule

@@ design/ptfm_core.sv @@
module ptfm_core
  import ptfm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      restart_req,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  logic [DIV_W-1:0] div_r, div_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic             dn_r, dn_nxt;
  logic [1:0]       lv_r, lv_nxt;
  logic             ovf_r, ovf_nxt;
  logic             rp_r, rp_nxt;
  logic             ev;

  logic [1:0]       rs_lv;
  logic [CNT_W-1:0] rs_cnt;
  logic             rs_dn;
  logic [PER_W-1:0] period;
  logic [PER_W-1:0] div_inc;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] cnt_up;
  logic [CNT_W-1:0] cnt_dn;

  // Window levels of the ramp modes, gated by the output enables; {a, b}
  function automatic logic [1:0] emit_lv(cfg_t c, logic [CNT_W-1:0] cn, logic [1:0] p,
                                         logic [1:0] cur);
    logic       wa;
    logic       wb;
    logic [1:0] res;
    wa  = 1'b0;
    wb  = 1'b0;
    res = cur;
    unique case (c.wave_mode)
      MODE_ONE_RAMP: begin
        wa = (cn >= c.a_set) && (cn < c.a_clear);
        wb = (cn >= c.b_set) && (cn < c.b_clear);
      end
      MODE_TWO_RAMP: begin
        if (p == 2'd0) wa = (cn >= c.a_set) && (cn < c.a_clear);
        else           wb = (cn >= c.b_set) && (cn < c.b_clear);
      end
      MODE_FOUR_RAMP: begin
        wa = (p == 2'd1);
        wb = (p == 2'd3);
      end
      MODE_DUAL_SLOPE: begin
        wa = cur[1];
        wb = cur[0];
      end
    endcase
    if (c.wave_mode != MODE_DUAL_SLOPE) begin
      if (c.output_enable[0]) res[1] = wa;
      if (c.output_enable[1]) res[0] = wb;
    end
    return res;
  endfunction

  // Compare matches of the dual slope; {a, b}
  function automatic logic [1:0] slope_lv(cfg_t c, logic [CNT_W-1:0] cn, logic down,
                                          logic [1:0] cur);
    logic [1:0] res;
    res = cur;
    if (cn == c.a_set && c.output_enable[0]) res[1] = !down;
    if (cn == c.b_set && c.output_enable[1]) res[0] = down;
    return res;
  endfunction

  // Prescale period: sync factor times count factor
  always_comb begin
    case (cfg.count_divide)
      2'd0:    period = PER_W'(1);
      2'd1:    period = PER_W'(4);
      default: period = PER_W'(32);
    endcase
    period = period << cfg.sync_divide;
  end

  // Phase limit of the ramp modes
  always_comb begin
    case (cfg.wave_mode)
      MODE_TWO_RAMP:  limit = (ph_r == 2'd0) ? cfg.a_clear : cfg.b_clear;
      MODE_FOUR_RAMP: begin
        case (ph_r)
          2'd0:    limit = cfg.a_set;
          2'd1:    limit = cfg.a_clear;
          2'd2:    limit = cfg.b_set;
          default: limit = cfg.b_clear;
        endcase
      end
      default:        limit = cfg.b_clear;
    endcase
  end

  // Restart targets: dual slope loads the top and drops the enabled outputs; ramp modes start from zero
  always_comb begin
    if (cfg.wave_mode == MODE_DUAL_SLOPE) begin
      rs_cnt = cfg.b_clear;
      rs_dn  = 1'b1;
      rs_lv  = lv_r;
      if (cfg.output_enable[0]) rs_lv[1] = 1'b0;
      if (cfg.output_enable[1]) rs_lv[0] = 1'b0;
    end else begin
      rs_cnt = '0;
      rs_dn  = 1'b0;
      rs_lv  = emit_lv(cfg, '0, 2'd0, lv_r);
    end
  end

  assign div_inc = {1'b0, div_r} + PER_W'(1);
  assign cnt_up  = cnt_r + CNT_W'(1);
  assign cnt_dn  = cnt_r - CNT_W'(1);

  // Next state for one tick, or a restart on a run start or after a register write while running
  always_comb begin
    div_nxt = div_r;
    cnt_nxt = cnt_r;
    ph_nxt  = ph_r;
    dn_nxt  = dn_r;
    lv_nxt  = lv_r;
    ovf_nxt = ovf_r;
    rp_nxt  = rp_r;
    ev      = 1'b0;
    if ((restart_req && rp_r) || (fire && item.run && !rp_r)) begin
      div_nxt = '0;
      ph_nxt  = 2'd0;
      cnt_nxt = rs_cnt;
      dn_nxt  = rs_dn;
      lv_nxt  = rs_lv;
    end else if (fire && item.run) begin
      if (div_inc >= period) begin
        div_nxt = '0;
        if (cfg.wave_mode == MODE_DUAL_SLOPE) begin
          if (dn_r) begin
            // turn at zero, holding it for one count
            if (cnt_r == '0) begin
              dn_nxt = 1'b0;
            end else begin
              cnt_nxt = cnt_dn;
              lv_nxt  = slope_lv(cfg, cnt_dn, 1'b1, lv_r);
            end
          end else if (cnt_r >= cfg.b_clear) begin
            dn_nxt  = 1'b1;
            cnt_nxt = cfg.b_clear;
            ev      = 1'b1;
          end else begin
            cnt_nxt = cnt_up;
            lv_nxt  = slope_lv(cfg, cnt_up, 1'b0, lv_r);
          end
        end else if (cnt_r >= limit) begin
          cnt_nxt = '0;
          if (cfg.wave_mode == MODE_TWO_RAMP && ph_r == 2'd0) begin
            ph_nxt = 2'd1;
          end else if (cfg.wave_mode == MODE_FOUR_RAMP && ph_r != 2'd3) begin
            ph_nxt = ph_r + 2'd1;
          end else begin
            ph_nxt = 2'd0;
            ev     = 1'b1;
          end
          lv_nxt = emit_lv(cfg, '0, ph_nxt, lv_r);
        end else begin
          cnt_nxt = cnt_up;
          lv_nxt  = emit_lv(cfg, cnt_up, ph_r, lv_r);
        end
      end else begin
        div_nxt = div_inc[DIV_W-1:0];
      end
    end
    if (fire) begin
      rp_nxt = item.run;
      if (item.clear_overflow) ovf_nxt = 1'b0;
      if (ev) ovf_nxt = 1'b1;
    end
  end

  // Hold the timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0;
      cnt_r <= '0;
      ph_r  <= 2'd0;
      dn_r  <= 1'b0;
      lv_r  <= 2'b00;
      ovf_r <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      div_r <= div_nxt;
      cnt_r <= cnt_nxt;
      ph_r  <= ph_nxt;
      dn_r  <= dn_nxt;
      lv_r  <= lv_nxt;
      ovf_r <= ovf_nxt;
      rp_r  <= rp_nxt;
    end
  end

  // Result of this tick, taken from the updated state
  always_comb begin
    result.wave_a         = lv_nxt[1];
    result.wave_b         = lv_nxt[0];
    result.count_value    = cnt_nxt;
    result.ramp_phase     = ph_nxt;
    result.counting_down  = dn_nxt;
    result.overflow_event = ev;
    result.overflow_flag  = ovf_nxt;
  end

endmodule

@@ design/pwm_timer_four_mode_12bit_top.sv @@
// A tick beat taken into the input register gives its result beat in the result
// register once that is empty or drained. Throughput: one beat per cycle unless
// the output stalls; the tick logic between the two registers updates the timer state.
// A register write while running restarts the counter in the cycle after the write.
// Reset: synchronous, active low; clears registers, timer state and the valid flags of both stages.
`include "pwm_timer_four_mode_12bit_top_defines.svh"
module pwm_timer_four_mode_12bit_top
  import ptfm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t      cfg;
  logic      restart_req;
  logic      in_hold_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t result;
  logic      move;
  logic      fire;

  ptfm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cfg         (cfg),
    .restart_req (restart_req)
  );

  ptfm_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .restart_req (restart_req),
    .fire        (fire),
    .item        (in_data_r),
    .result      (result)
  );

  // Advance when the result register is empty or being drained
  assign move     = !out_valid_r || !out_stall;
  assign fire     = in_hold_r && move;
  assign in_stall = in_hold_r && !move;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_hold_r <= 1'b0;
    end else if (!in_stall) begin
      in_hold_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= in_hold_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An overflow beat always carries the sticky flag
  `PTFM_ASSERT_IMP(a_ovf_flag, out_valid_r && out_data_r.overflow_event, out_data_r.overflow_flag, "overflow event without flag")
  // A processed tick always lands in the result register
  `PTFM_ASSERT_NXT(a_fire_out, fire, out_valid_r, "processed tick lost")
  // A held tick that is not processed stays held
  `PTFM_ASSERT_NXT(a_hold_keep, in_hold_r && !fire, in_hold_r, "held tick dropped")

endmodule

@@ test/testbench.sv @@
module testbench;
  import ptfm_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  pwm_timer_four_mode_12bit_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timer model state: registers plus counter state
  cfg_t             tmr_cfg = '0;
  logic [DIV_W-1:0] prescale_cnt = '0;
  logic [CNT_W-1:0] count_q = '0;
  logic [1:0]       phase_q = '0;
  logic             down_q = 1'b0;
  logic             lvl_a = 1'b0;
  logic             lvl_b = 1'b0;
  logic             ovf_sticky = 1'b0;
  logic             run_seen = 1'b0;

  out_item_t   due_outputs [$];
  out_item_t   due_head;
  int unsigned fail_count = 0;
  int unsigned beats_seen = 0;
  int unsigned hold_left = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Move an output level only when its enable bit allows it
  function automatic void set_level(bit on_a, bit lvl);
    if (on_a) begin
      if (tmr_cfg.output_enable[0]) lvl_a = lvl;
    end else if (tmr_cfg.output_enable[1]) begin
      lvl_b = lvl;
    end
  endfunction

  function automatic bit in_window(logic [CNT_W-1:0] c, logic [CNT_W-1:0] lo,
                                   logic [CNT_W-1:0] hi);
    return (c >= lo) && (c < hi);
  endfunction

  // Ramp modes: derive both levels from count and phase
  function automatic void ramp_levels();
    bit wa;
    bit wb;
    wa = 1'b0;
    wb = 1'b0;
    case (tmr_cfg.wave_mode)
      MODE_ONE_RAMP: begin
        wa = in_window(count_q, tmr_cfg.a_set, tmr_cfg.a_clear);
        wb = in_window(count_q, tmr_cfg.b_set, tmr_cfg.b_clear);
      end
      MODE_TWO_RAMP: begin
        if (phase_q == 2'd0) wa = in_window(count_q, tmr_cfg.a_set, tmr_cfg.a_clear);
        else wb = in_window(count_q, tmr_cfg.b_set, tmr_cfg.b_clear);
      end
      MODE_FOUR_RAMP: begin
        wa = (phase_q == 2'd1);
        wb = (phase_q == 2'd3);
      end
      default: return;
    endcase
    set_level(1'b1, wa);
    set_level(1'b0, wb);
  endfunction

  function automatic void restart_timer();
    prescale_cnt = '0;
    phase_q = '0;
    if (tmr_cfg.wave_mode == MODE_DUAL_SLOPE) begin
      down_q = 1'b1;
      count_q = tmr_cfg.b_clear;
      set_level(1'b1, 1'b0);
      set_level(1'b0, 1'b0);
    end else begin
      down_q = 1'b0;
      count_q = '0;
      ramp_levels();
    end
  endfunction

  // Dual slope compares: direction decides which edge each match makes
  function automatic void slope_compare();
    if (down_q) begin
      if (count_q == tmr_cfg.b_set) set_level(1'b0, 1'b1);
      if (count_q == tmr_cfg.a_set) set_level(1'b1, 1'b0);
    end else begin
      if (count_q == tmr_cfg.a_set) set_level(1'b1, 1'b1);
      if (count_q == tmr_cfg.b_set) set_level(1'b0, 1'b0);
    end
  endfunction

  // Take one count; return 1 when the whole period ends
  function automatic bit advance_count();
    logic [CNT_W-1:0] limit;
    bit               ev;
    ev = 1'b0;
    if (tmr_cfg.wave_mode == MODE_DUAL_SLOPE) begin
      if (down_q) begin
        if (count_q == '0) down_q = 1'b0;
        else begin
          count_q = count_q - 1'b1;
          slope_compare();
        end
        return 1'b0;
      end
      if (count_q >= tmr_cfg.b_clear) begin
        down_q = 1'b1;
        count_q = tmr_cfg.b_clear;
        return 1'b1;
      end
      count_q = count_q + 1'b1;
      slope_compare();
      return 1'b0;
    end
    case (tmr_cfg.wave_mode)
      MODE_TWO_RAMP: limit = (phase_q == 2'd0) ? tmr_cfg.a_clear : tmr_cfg.b_clear;
      MODE_FOUR_RAMP: begin
        case (phase_q)
          2'd0: limit = tmr_cfg.a_set;
          2'd1: limit = tmr_cfg.a_clear;
          2'd2: limit = tmr_cfg.b_set;
          default: limit = tmr_cfg.b_clear;
        endcase
      end
      default: limit = tmr_cfg.b_clear;
    endcase
    if (count_q >= limit) begin
      count_q = '0;
      if (tmr_cfg.wave_mode == MODE_TWO_RAMP && phase_q == 2'd0) phase_q = 2'd1;
      else if (tmr_cfg.wave_mode == MODE_FOUR_RAMP && phase_q < 2'd3) phase_q = phase_q + 1'b1;
      else begin
        phase_q = '0;
        ev = 1'b1;
      end
      ramp_levels();
      return ev;
    end
    count_q = count_q + 1'b1;
    ramp_levels();
    return 1'b0;
  endfunction

  // One tick beat of the timer
  function automatic out_item_t timer_tick(in_item_t it);
    bit          ev;
    int unsigned period;
    out_item_t   r;
    ev = 1'b0;
    if (it.run && !run_seen) restart_timer();
    else if (it.run) begin
      period = (1 << tmr_cfg.sync_divide) *
               ((tmr_cfg.count_divide == 2'd0) ? 1 : (tmr_cfg.count_divide == 2'd1) ? 4 : 32);
      if (prescale_cnt + 1 >= period) begin
        prescale_cnt = '0;
        ev = advance_count();
      end else begin
        prescale_cnt = prescale_cnt + 1'b1;
      end
    end
    run_seen = it.run;
    if (it.clear_overflow) ovf_sticky = 1'b0;
    if (ev) ovf_sticky = 1'b1;
    r.wave_a = lvl_a;
    r.wave_b = lvl_b;
    r.count_value = count_q;
    r.ramp_phase = phase_q;
    r.counting_down = down_q;
    r.overflow_event = ev;
    r.overflow_flag = ovf_sticky;
    return r;
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
    case (idx)
      IDX_WAVE_MODE:     tmr_cfg.wave_mode = wave_mode_t'(v[1:0]);
      IDX_A_SET:         tmr_cfg.a_set = v;
      IDX_A_CLEAR:       tmr_cfg.a_clear = v;
      IDX_B_SET:         tmr_cfg.b_set = v;
      IDX_B_CLEAR:       tmr_cfg.b_clear = v;
      IDX_OUTPUT_ENABLE: tmr_cfg.output_enable = v[1:0];
      IDX_SYNC_DIVIDE:   tmr_cfg.sync_divide = v[1:0];
      default:           tmr_cfg.count_divide = v[1:0];
    endcase
    // a write while running restarts the counter
    if (run_seen) restart_timer();
  endfunction

  // Offer one tick beat, with random gaps, and queue its expected output
  task automatic send_tick(in_item_t it, bit fixed, out_item_t want);
    out_item_t pred;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = timer_tick(it);
    due_outputs.push_back(fixed ? want : pred);
  endtask

  // Write one register once the block has drained
  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    apply_reg(idx, v);
    cfg_we <= 1'b0;
    // let the restart that follows a write settle
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_compare(int unsigned top);
    if ($urandom_range(5) == 0) return CFG_W'($urandom_range(4095));
    return CFG_W'($urandom_range(top + 2));
  endfunction

  // Program all registers: the extremes first, then random settings
  task automatic program_phase(int n);
    logic [CFG_W-1:0] vals [8];
    int unsigned      top;
    int               i;
    if (n == 0) begin
      vals = '{12'd3, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'd3, 12'd3, 12'd3};
    end else if (n == 1) begin
      vals = '{default: '0};
    end else begin
      top = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(20);
      vals[IDX_WAVE_MODE] = CFG_W'($urandom_range(3));
      vals[IDX_A_SET] = pick_compare(top);
      vals[IDX_A_CLEAR] = pick_compare(top);
      vals[IDX_B_SET] = pick_compare(top);
      vals[IDX_B_CLEAR] = CFG_W'(top);
      vals[IDX_OUTPUT_ENABLE] = CFG_W'($urandom_range(3));
      vals[IDX_SYNC_DIVIDE] = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(3)) : '0;
      vals[IDX_COUNT_DIVIDE] = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(3)) : '0;
    end
    for (i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), vals[i]);
  endtask

  // Directed plan: register writes and tick beats, some with fixed outputs
  typedef struct packed {
    bit               is_write;
    cfg_idx_t         idx;
    logic [CFG_W-1:0] val;
    in_item_t         tick;
    bit               fixed;
    out_item_t        want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic plan_row_t reg_row(cfg_idx_t idx, logic [CFG_W-1:0] v);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx = idx;
    r.val = v;
    return r;
  endfunction

  function automatic plan_row_t tick_row(bit run, bit clr, bit fixed, out_item_t want);
    plan_row_t r;
    r = '0;
    r.tick.run = run;
    r.tick.clear_overflow = clr;
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  // field order: wave_a, wave_b, count, phase, down, event, flag
  function automatic out_item_t beat_of(bit a, bit b, int cnt, int ph, bit dn, bit ev, bit fl);
    return {a, b, cnt[CNT_W-1:0], ph[1:0], dn, ev, fl};
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Check every output beat against the oldest expectation; drive receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_outputs.size() == 0) begin
        $display("%0t: output beat with nothing due, got %h", $time, out_data);
        fail_count++;
      end else begin
        due_head = due_outputs.pop_front();
        check_field("wave_a", due_head.wave_a, out_data.wave_a);
        check_field("wave_b", due_head.wave_b, out_data.wave_b);
        check_field("count_value", due_head.count_value, out_data.count_value);
        check_field("ramp_phase", due_head.ramp_phase, out_data.ramp_phase);
        check_field("counting_down", due_head.counting_down, out_data.counting_down);
        check_field("overflow_event", due_head.overflow_event, out_data.overflow_event);
        check_field("overflow_flag", due_head.overflow_flag, out_data.overflow_flag);
        beats_seen++;
        // hold off long enough to back the block up into its input
        if (beats_seen == 200 || beats_seen == 800) hold_left = 60;
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    int       seg;
    int       ph;
    int       k;
    bit       run_lvl;
    in_item_t it;

    // after reset: run low, restart, zero top overflowing every count
    plan.push_back(tick_row(1'b0, 1'b0, 1'b1, beat_of(0, 0, 0, 0, 0, 0, 0)));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b1, beat_of(0, 0, 0, 0, 0, 0, 0)));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b1, beat_of(0, 0, 0, 0, 0, 1, 1)));
    // overflow wins over a clear in the same cycle
    plan.push_back(tick_row(1'b1, 1'b1, 1'b1, beat_of(0, 0, 0, 0, 0, 1, 1)));
    plan.push_back(tick_row(1'b0, 1'b1, 1'b1, beat_of(0, 0, 0, 0, 0, 0, 0)));
    // widest windows, written while stopped
    plan.push_back(reg_row(IDX_OUTPUT_ENABLE, 12'd3));
    plan.push_back(reg_row(IDX_A_CLEAR, 12'hfff));
    plan.push_back(reg_row(IDX_B_SET, 12'hfff));
    plan.push_back(reg_row(IDX_B_CLEAR, 12'hfff));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b1, beat_of(1, 0, 0, 0, 0, 0, 0)));
    // write while running restarts
    plan.push_back(reg_row(IDX_B_SET, 12'd1));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b0, '0));
    // two ramp
    plan.push_back(reg_row(IDX_WAVE_MODE, CFG_W'(MODE_TWO_RAMP)));
    plan.push_back(reg_row(IDX_A_SET, 12'd1));
    plan.push_back(reg_row(IDX_A_CLEAR, 12'd2));
    plan.push_back(reg_row(IDX_B_SET, 12'd0));
    plan.push_back(reg_row(IDX_B_CLEAR, 12'd1));
    for (k = 0; k < 4; k++) plan.push_back(tick_row(1'b1, k[0], 1'b0, '0));
    // four ramp
    plan.push_back(reg_row(IDX_WAVE_MODE, CFG_W'(MODE_FOUR_RAMP)));
    plan.push_back(reg_row(IDX_A_SET, 12'd0));
    plan.push_back(reg_row(IDX_A_CLEAR, 12'd1));
    plan.push_back(reg_row(IDX_B_CLEAR, 12'd2));
    for (k = 0; k < 5; k++) plan.push_back(tick_row(1'b1, 1'b0, 1'b0, '0));
    // dual slope through both turns and both compares each way
    plan.push_back(reg_row(IDX_WAVE_MODE, CFG_W'(MODE_DUAL_SLOPE)));
    plan.push_back(reg_row(IDX_A_SET, 12'd1));
    plan.push_back(reg_row(IDX_B_SET, 12'd2));
    plan.push_back(reg_row(IDX_B_CLEAR, 12'd3));
    for (k = 0; k < 9; k++) plan.push_back(tick_row(1'b1, 1'b0, 1'b0, '0));

    send_gap_pct = 36;
    recv_stall_pct = 70;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].is_write) write_reg(plan[k].idx, plan[k].val);
      else send_tick(plan[k].tick, plan[k].fixed, plan[k].want);
    end

    // random part: three idling profiles, four register settings each
    run_lvl = 1'b1;
    for (seg = 0; seg < 3; seg++) begin
      send_gap_pct = (seg == 0) ? 36 : (seg == 1) ? 70 : 0;
      recv_stall_pct = (seg == 0) ? 70 : (seg == 1) ? 36 : 0;
      for (ph = 0; ph < 4; ph++) begin
        program_phase(seg * 4 + ph);
        for (k = 0; k < 100; k++) begin
          run_lvl = run_lvl ? ($urandom_range(99) < 97) : ($urandom_range(99) < 60);
          it.run = run_lvl;
          it.clear_overflow = ($urandom_range(99) < 15);
          send_tick(it, 1'b0, '0);
        end
      end
    end
    in_valid <= 1'b0;

    // drain, then allow for the output register
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("pwm_timer_four_mode_12bit_top verification clean");
    end else begin
      $display("pwm_timer_four_mode_12bit_top verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("pwm_timer_four_mode_12bit_top verification failed");
    $finish;
  end

endmodule

@@ pwm_timer_four_mode_12bit_top.f @@
+incdir+design
design/ptfm_pkg.sv
design/ptfm_regs.sv
design/ptfm_core.sv
design/pwm_timer_four_mode_12bit_top.sv
test/testbench.sv
